// ===== rtl/apmd_pkg.sv =====
// ----------------------------------------------------------------------------
// apmd_pkg: shared types and constants for the angle PID motor drive
// Field widths, derived datapath widths, reset values, register indexes
// and the request payload structs.
// ----------------------------------------------------------------------------
package apmd_pkg;

  localparam int ANGLE_BITS     = 12;
  localparam int GAIN_W         = 32;
  localparam int GAIN_FRAC_BITS = 32;
  localparam int DT_W           = 16;
  localparam int ILIM_W         = 24;
  localparam int DUTY_W         = 8;
  localparam int TOL_W          = 12;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;

  localparam int HALF_TURN = 1 << (ANGLE_BITS - 1);
  localparam int TURN      = 1 << ANGLE_BITS;
  localparam int D_SCALE   = 1000;  // derivative in counts per second

  // derived widths
  localparam int WRAP_W  = ANGLE_BITS + 2;          // raw target - angle
  localparam int ERR_W   = ANGLE_BITS + 1;          // wrapped error, +-half turn
  localparam int DERR_W  = ERR_W + 1;               // error difference
  localparam int DSCL_W  = ANGLE_BITS + 10;         // |de| * 1000
  localparam int NUM_W   = GAIN_W + DSCL_W;         // derivative numerator
  localparam int INTEG_W = ILIM_W + 1;              // signed integral
  localparam int PROD_W  = ERR_W + DT_W + 1;        // e * dt
  localparam int SUM_W   = PROD_W + 1;              // integral + e * dt
  localparam int ACC_W   = GAIN_W + INTEG_W + 2;    // PID sum
  localparam int RQ_W    = ACC_W + 1 - GAIN_FRAC_BITS;
  localparam int MAG_W   = DUTY_W + 1;              // saturated rounded magnitude
  localparam int CMD_W   = DUTY_W + 1;              // signed command
  localparam int DELTA_W = DUTY_W + 2;              // command arithmetic
  localparam int MCNT_W  = $clog2(GAIN_W);

  localparam logic [ACC_W:0] RND_HALF =
    {{(ACC_W - GAIN_FRAC_BITS + 1){1'b0}}, 1'b1, {(GAIN_FRAC_BITS - 1){1'b0}}};

  // reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd1132462080;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd75497;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd150994944;
  localparam logic [ILIM_W-1:0] ILIM_RST       = 24'd13084444;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 8'd230;
  localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = 8'd60;
  localparam logic [TOL_W-1:0]  TOL_RST        = 12'd17;
  localparam logic [DUTY_W-1:0] SLEW_RST       = 8'd5;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 4'd0,
    CFG_INTEG_GAIN = 4'd1,
    CFG_DERIV_GAIN = 4'd2,
    CFG_ILIM       = 4'd3,
    CFG_DUTY_MAX   = 4'd4,
    CFG_DUTY_MIN   = 4'd5,
    CFG_TOL        = 4'd6,
    CFG_SLEW       = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                  kind;
    logic [ANGLE_BITS-1:0] angle_value;
    logic [DT_W-1:0]       elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              forward;
    logic              in_band;
  } drv_t;

endpackage

// ===== rtl/apmd_div.sv =====
// ----------------------------------------------------------------------------
// apmd_div: serial unsigned divider
// Restoring division, two quotient bits per cycle; quotient truncated.
// ----------------------------------------------------------------------------
module apmd_div import apmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DT_W-1:0]  divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int DIV_W = NUM_W + (NUM_W % 2);
  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DT_W-1:0]  rem;
  logic [DIV_W-1:0] sh;
  logic [DT_W:0]    r1, r2, d1, d2;
  logic [DT_W-1:0]  rem1, rem2;
  logic             ge1, ge2;

  always_comb begin
    r1   = {rem, sh[DIV_W-1]};
    d1   = r1 - {1'b0, divisor};
    ge1  = (r1 >= {1'b0, divisor});
    rem1 = ge1 ? d1[DT_W-1:0] : r1[DT_W-1:0];
    r2   = {rem1, sh[DIV_W-2]};
    d2   = r2 - {1'b0, divisor};
    ge2  = (r2 >= {1'b0, divisor});
    rem2 = ge2 ? d2[DT_W-1:0] : r2[DT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        sh   <= DIV_W'(dividend);
        rem  <= '0;
        cnt  <= CNT_W'(STEPS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= {sh[DIV_W-3:0], ge1, ge2};
        rem <= rem2;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = sh[NUM_W-1:0];

endmodule

// ===== rtl/angle_pid_motor_drive.sv =====
// ----------------------------------------------------------------------------
// angle_pid_motor_drive: PID position loop with slew limit for one joint
// Wrap, tolerance band, PID with integral clamp, output shaping.
// ----------------------------------------------------------------------------
// A set-target request gives no result and leaves the block idle. A tick inside the
// tolerance band goes through CHECK and then EMIT, which loads the output register;
// any other tick goes through CHECK, INTEG, MUL, DIV, ADD, RND, SHAPE and EMIT,
// and EMIT waits while the output is stalled. The work is done by the bit-serial
// multiply (one gain bit per cycle, with all three gains shifted in parallel) and
// the divider of the derivative term (two quotient bits per cycle). A finished result
// waits in the output register while the next request is being worked on.
// Configuration writes are always ready and are meant for idle periods.
module angle_pid_motor_drive import apmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  drv_valid,
  input  logic                  drv_stall,
  output drv_t                  drv,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHECK = 9'b000000010,
    ST_INTEG = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_ADD   = 9'b000100000,
    ST_RND   = 9'b001000000,
    ST_SHAPE = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [GAIN_W-1:0] prop_gain, integ_gain, deriv_gain;
  logic [ILIM_W-1:0] integral_limit;
  logic [DUTY_W-1:0] duty_max, duty_min, slew_step;
  logic [TOL_W-1:0]  tolerance_counts;

  // loop state
  logic [ANGLE_BITS-1:0]     target_angle;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [INTEG_W-1:0] integ;
  logic signed [CMD_W-1:0]   last_cmd;

  // working registers
  logic signed [ERR_W-1:0]  e_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     dneg;
  logic [DSCL_W-1:0]        dscl;
  logic [GAIN_W-1:0]        pg_sh, ig_sh, dg_sh;
  logic signed [ACC_W-1:0]  acc;
  logic [NUM_W-1:0]         numd;
  logic [MCNT_W-1:0]        mcnt;
  logic [MAG_W-1:0]         rmag;
  logic                     uneg;
  drv_t                     res;
  logic                     div_start, div_done;
  logic [NUM_W-1:0]         quo;

  // combinational
  logic signed [WRAP_W-1:0]  e_raw, e_adj;
  logic signed [ERR_W-1:0]   e_next;
  logic [DT_W-1:0]           dt_next;
  logic [ERR_W-1:0]          e_mag;
  logic                      band;
  logic signed [DERR_W-1:0]  de;
  logic [DERR_W-1:0]         dmag;
  logic [DSCL_W-1:0]         dscl_next;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [SUM_W-1:0]   isum, ilim, integ_sum;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [ACC_W-1:0]   pe, pi, dq;
  logic [ACC_W-1:0]          amag;
  logic [ACC_W:0]            rsum;
  logic [RQ_W-1:0]           rq;
  logic [MAG_W-1:0]          m1, m2, dmax, dmin;
  logic                      cneg;
  logic signed [DELTA_W-1:0] cmdv, lastx, delta, slw, cmd_fin, cmd_abs;

  localparam logic signed [WRAP_W-1:0] WRAP_HALF = WRAP_W'(HALF_TURN);
  localparam logic signed [WRAP_W-1:0] WRAP_TURN = WRAP_W'(TURN);

  assign cmd_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // error wrap to the shortest path
  always_comb begin
    e_raw = $signed({2'b00, target_angle}) - $signed({2'b00, cmd.angle_value});
    if (e_raw > WRAP_HALF) begin
      e_adj = e_raw - WRAP_TURN;
    end else if (e_raw < -WRAP_HALF) begin
      e_adj = e_raw + WRAP_TURN;
    end else begin
      e_adj = e_raw;
    end
    e_next  = e_adj[ERR_W-1:0];
    dt_next = (cmd.elapsed_ms == '0) ? DT_W'(1) : cmd.elapsed_ms;
  end

  // band test, derivative numerator scale, e * dt
  always_comb begin
    e_mag     = e_r[ERR_W-1] ? ERR_W'(-e_r) : ERR_W'(e_r);
    band      = ({1'b0, e_mag} <= {2'b00, tolerance_counts});
    de        = DERR_W'(e_r) - DERR_W'(last_error);
    dmag      = de[DERR_W-1] ? DERR_W'(-de) : DERR_W'(de);
    dscl_next = DSCL_W'(dmag) * DSCL_W'(D_SCALE);
    prod_next = e_r * $signed({1'b0, dt_r});
  end

  // integral update with clamp
  always_comb begin
    isum = SUM_W'(integ) + SUM_W'(prod_r);
    ilim = $signed(SUM_W'({1'b0, integral_limit}));
    if (isum > ilim) begin
      integ_sum = ilim;
    end else if (isum < -ilim) begin
      integ_sum = -ilim;
    end else begin
      integ_sum = isum;
    end
    integ_next = integ_sum[INTEG_W-1:0];
  end

  // shift-add terms, derivative quotient, rounding
  always_comb begin
    pe   = pg_sh[GAIN_W-1] ? ACC_W'(e_r) : '0;
    pi   = ig_sh[GAIN_W-1] ? ACC_W'(integ) : '0;
    dq   = dneg ? -$signed(ACC_W'(quo)) : $signed(ACC_W'(quo));
    amag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rsum = {1'b0, amag} + RND_HALF;
    rq   = rsum[ACC_W:GAIN_FRAC_BITS];
  end

  // output clamp, minimum magnitude, slew limit
  always_comb begin
    dmax  = {1'b0, duty_max};
    dmin  = {1'b0, duty_min};
    m1    = (rmag > dmax) ? dmax : rmag;
    m2    = (m1 < dmin) ? dmin : m1;
    cneg  = uneg && (m1 != '0);
    cmdv  = cneg ? -$signed(DELTA_W'(m2)) : $signed(DELTA_W'(m2));
    lastx = DELTA_W'(last_cmd);
    delta = cmdv - lastx;
    slw   = $signed(DELTA_W'(slew_step));
    if (delta > slw) begin
      cmd_fin = lastx + slw;
    end else if (delta < -slw) begin
      cmd_fin = lastx - slw;
    end else begin
      cmd_fin = cmdv;
    end
    cmd_abs = cmd_fin[DELTA_W-1] ? -cmd_fin : cmd_fin;
  end

  apmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numd),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      drv_valid        <= 1'b0;
      div_start        <= 1'b0;
      prop_gain        <= PROP_GAIN_RST;
      integ_gain       <= INTEG_GAIN_RST;
      deriv_gain       <= DERIV_GAIN_RST;
      integral_limit   <= ILIM_RST;
      duty_max         <= DUTY_MAX_RST;
      duty_min         <= DUTY_MIN_RST;
      tolerance_counts <= TOL_RST;
      slew_step        <= SLEW_RST;
      target_angle     <= ANGLE_BITS'(HALF_TURN);
      last_error       <= '0;
      integ            <= '0;
      last_cmd         <= '0;
    end else begin
      // divider kicks off once the last gain bit is in
      div_start <= (state == ST_MUL) && (mcnt == '0);
      if (drv_valid && !drv_stall && state != ST_EMIT) begin
        drv_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_PROP_GAIN:  prop_gain        <= cfg_data[GAIN_W-1:0];
          CFG_INTEG_GAIN: integ_gain       <= cfg_data[GAIN_W-1:0];
          CFG_DERIV_GAIN: deriv_gain       <= cfg_data[GAIN_W-1:0];
          CFG_ILIM:       integral_limit   <= cfg_data[ILIM_W-1:0];
          CFG_DUTY_MAX:   duty_max         <= cfg_data[DUTY_W-1:0];
          CFG_DUTY_MIN:   duty_min         <= cfg_data[DUTY_W-1:0];
          CFG_TOL:        tolerance_counts <= cfg_data[TOL_W-1:0];
          CFG_SLEW:       slew_step        <= cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && !cmd_stall) begin
            if (cmd.kind == KIND_TARGET) begin
              target_angle <= cmd.angle_value;
              integ        <= '0;
              last_error   <= '0;
            end else begin
              e_r   <= e_next;
              dt_r  <= dt_next;
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          last_error <= e_r;
          if (band) begin
            integ       <= '0;
            res.duty    <= '0;
            res.forward <= 1'b0;
            res.in_band <= 1'b1;
            state       <= ST_EMIT;
          end else begin
            prod_r <= prod_next;
            dneg   <= de[DERR_W-1];
            dscl   <= dscl_next;
            state  <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integ <= integ_next;
          pg_sh <= prop_gain;
          ig_sh <= integ_gain;
          dg_sh <= deriv_gain;
          acc   <= '0;
          numd  <= '0;
          mcnt  <= MCNT_W'(GAIN_W - 1);
          state <= ST_MUL;
        end
        ST_MUL: begin
          // gains MSB first: acc = 2*acc + selected multiplicands
          acc   <= (acc <<< 1) + pe + pi;
          numd  <= (numd << 1) + (dg_sh[GAIN_W-1] ? NUM_W'(dscl) : '0);
          pg_sh <= pg_sh << 1;
          ig_sh <= ig_sh << 1;
          dg_sh <= dg_sh << 1;
          mcnt  <= mcnt - 1'b1;
          if (mcnt == '0) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          acc   <= acc + dq;
          state <= ST_RND;
        end
        ST_RND: begin
          // round half away from zero, saturate well above any duty limit
          rmag  <= (|rq[RQ_W-1:MAG_W]) ? '1 : rq[MAG_W-1:0];
          uneg  <= acc[ACC_W-1];
          state <= ST_SHAPE;
        end
        ST_SHAPE: begin
          last_cmd    <= cmd_fin[CMD_W-1:0];
          res.duty    <= cmd_abs[DUTY_W-1:0];
          res.forward <= (cmd_fin > 0);
          res.in_band <= 1'b0;
          state       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!drv_valid || !drv_stall) begin
            drv       <= res;
            drv_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
